>>> rtl/rws_pkg.sv
package rws_pkg;

    localparam int POP_MAX     = 64;
    localparam int IDX_W       = $clog2(POP_MAX);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WEIGHT_BITS = 24;
    localparam int STORE_W     = WEIGHT_BITS - 1;
    localparam int TOTAL_W     = STORE_W + IDX_W;
    localparam int RAND_W      = 16;
    localparam int PROD_W      = RAND_W + TOTAL_W;
    localparam int POP_W       = 7;
    localparam int SEL_W       = 6;
    localparam int DIV_CNT_W   = $clog2(RAND_W + 1);

    localparam logic [POP_W-1:0] POP_RESET = POP_W'(64);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_SEL_PREP,
        ST_SUM,
        ST_CHECK,
        ST_SCAN,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_rd;
        logic load_wr;
        logic use_total;
        logic scan_start;
        logic rd_issue;
        logic sum_latch;
        logic mul_thr;
        logic div_start;
        logic div_step;
        logic pick_hit;
        logic pick_last;
        logic pick_rem;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic p_full;
        logic sum_done;
        logic sum_zero;
        logic hit;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

>>> rtl/rws_if.sv
interface rws_in_if import rws_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [IDX_W-1:0]              entry_index;
    logic signed [WEIGHT_BITS-1:0] fitness_weight;
    logic [RAND_W-1:0]             random_word;

    modport source (output valid, output operation, output entry_index,
                    output fitness_weight, output random_word, input ready);
    modport sink   (input valid, input operation, input entry_index,
                    input fitness_weight, input random_word, output ready);
endinterface

interface rws_out_if import rws_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEL_W-1:0] selected_index;
    logic             used_uniform_fallback;

    modport source (output valid, output selected_index, output used_uniform_fallback,
                    input ready);
    modport sink   (input valid, input selected_index, input used_uniform_fallback,
                    output ready);
endinterface

>>> rtl/rws_ctrl.sv
module rws_ctrl import rws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_op,
    output logic    in_ready,
    output cmd_t    cmd,
    input  status_t st
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_op == OP_SELECT) ? ST_SEL_PREP : ST_LOAD_RD;
                end
            end
            ST_LOAD_RD:  state_next = ST_LOAD_WR;
            ST_LOAD_WR:  state_next = ST_IDLE;
            ST_SEL_PREP: state_next = st.p_full ? ST_CHECK : ST_SUM;
            ST_SUM:
            begin
                if (st.sum_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:    state_next = st.sum_zero ? ST_DIV : ST_SCAN;
            ST_SCAN:
            begin
                if (st.hit || st.sum_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOAD_RD:  cmd.load_rd = 1'b1;
            ST_LOAD_WR:  cmd.load_wr = 1'b1;
            ST_SEL_PREP:
            begin
                // full population: the running total is the sum already
                if (st.p_full)
                begin
                    cmd.use_total = 1'b1;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                end
            end
            ST_SUM:
            begin
                cmd.rd_issue  = 1'b1;
                cmd.sum_latch = st.sum_done;
            end
            ST_CHECK:
            begin
                if (st.sum_zero)
                begin
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.mul_thr    = 1'b1;
                    cmd.scan_start = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (st.hit)
                begin
                    cmd.pick_hit = 1'b1;
                end
                else if (st.sum_done)
                begin
                    cmd.pick_last = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.pick_rem = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FINISH:   cmd.out_load = st.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

>>> rtl/rws_datapath.sv
module rws_datapath import rws_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [POP_W-1:0]              cfg_wr_data,
    input  logic [IDX_W-1:0]              entry_index,
    input  logic signed [WEIGHT_BITS-1:0] fitness_weight,
    input  logic [RAND_W-1:0]             random_word,
    input  cmd_t                          cmd,
    output status_t                       st,
    rws_out_if.source                     results
);

    logic [STORE_W-1:0] mem [POP_MAX];
    logic [POP_MAX-1:0] valid_reg;

    logic [POP_W-1:0]     pop_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [STORE_W-1:0]   w_reg;
    logic [RAND_W-1:0]    rnd_reg;
    logic [CNT_W-1:0]     p_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [STORE_W-1:0]   rd_data_reg;
    logic                 rd_vld_reg;
    logic [TOTAL_W-1:0]   acc_reg;
    logic [TOTAL_W-1:0]   sum_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [RAND_W-1:0]    dvd_reg;
    logic [POP_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic                 fb_reg;
    logic                 out_valid_reg;
    logic [SEL_W-1:0]     out_idx_reg;
    logic                 out_fb_reg;

    logic [CNT_W-1:0]   p_next;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [STORE_W-1:0] rd_word;
    logic [TOTAL_W-1:0] acc_sum;
    logic [TOTAL_W-1:0] thr;
    logic [POP_W:0]     trial;
    logic [POP_W:0]     trial_sub;

    // population of zero counts as one, anything beyond the store saturates
    always_comb
    begin
        priority if (pop_reg == '0)
        begin
            p_next = CNT_W'(1);
        end
        else if (int'(pop_reg) > POP_MAX)
        begin
            p_next = CNT_W'(POP_MAX);
        end
        else
        begin
            p_next = CNT_W'(pop_reg);
        end
    end

    assign rd_en   = cmd.load_rd || (cmd.rd_issue && (cnt_reg < p_reg));
    assign rd_addr = cmd.load_rd ? idx_reg : cnt_reg[IDX_W-1:0];
    assign rd_word = rd_vld_reg ? rd_data_reg : '0;
    assign acc_sum = acc_reg + TOTAL_W'(rd_word);
    assign thr     = prod_reg[PROD_W-1:RAND_W];

    assign trial     = {rem_reg, dvd_reg[RAND_W-1]};
    assign trial_sub = trial - {1'b0, POP_W'(p_reg)};

    assign st.p_full   = (p_reg == CNT_W'(POP_MAX));
    assign st.sum_done = (cnt_reg == p_reg) && !pend_reg;
    assign st.sum_zero = (sum_reg == '0);
    assign st.hit      = pend_reg && (acc_sum >= thr);
    assign st.div_done = (dcnt_reg == DIV_CNT_W'(RAND_W));
    assign st.out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            mem[idx_reg] <= w_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            pop_reg       <= POP_RESET;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pop_reg <= cfg_wr_data;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (cmd.load_wr)
            begin
                valid_reg[idx_reg] <= 1'b1;
                total_reg          <= total_reg - TOTAL_W'(rd_word) + TOTAL_W'(w_reg);
            end
            if (cmd.scan_start)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.rd_issue)
            begin
                pend_reg <= (cnt_reg < p_reg);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= entry_index;
            w_reg   <= fitness_weight[WEIGHT_BITS-1] ? '0 : fitness_weight[STORE_W-1:0];
            rnd_reg <= random_word;
            p_reg   <= p_next;
        end

        if (cmd.scan_start)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.rd_issue)
        begin
            if (cnt_reg < p_reg)
            begin
                cnt_reg    <= cnt_reg + 1'b1;
                rd_idx_reg <= cnt_reg[IDX_W-1:0];
            end
            if (pend_reg)
            begin
                acc_reg <= acc_sum;
            end
        end

        if (cmd.use_total)
        begin
            sum_reg <= total_reg;
        end
        else if (cmd.sum_latch)
        begin
            sum_reg <= acc_reg;
        end

        if (cmd.mul_thr)
        begin
            prod_reg <= PROD_W'(rnd_reg) * PROD_W'(sum_reg);
        end

        // restoring remainder, one dividend bit a cycle
        if (cmd.div_start)
        begin
            dvd_reg  <= rnd_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg  <= trial_sub[POP_W] ? trial[POP_W-1:0] : trial_sub[POP_W-1:0];
            dcnt_reg <= dcnt_reg + 1'b1;
        end

        if (cmd.pick_hit)
        begin
            pick_reg <= rd_idx_reg;
            fb_reg   <= 1'b0;
        end
        else if (cmd.pick_last)
        begin
            pick_reg <= IDX_W'(p_reg - 1'b1);
            fb_reg   <= 1'b0;
        end
        else if (cmd.pick_rem)
        begin
            pick_reg <= rem_reg[IDX_W-1:0];
            fb_reg   <= 1'b1;
        end

        if (cmd.out_load)
        begin
            out_idx_reg <= SEL_W'(pick_reg);
            out_fb_reg  <= fb_reg;
        end
    end

    assign results.valid                 = out_valid_reg;
    assign results.selected_index        = out_idx_reg;
    assign results.used_uniform_fallback = out_fb_reg;

endmodule

>>> rtl/roulette_wheel_selector_top.sv
// Roulette-wheel selector. A load transfer writes one clamped weight (negative counts as zero)
// into a 64-entry store and returns nothing. A select transfer returns one index. With the
// full population in use the stored running total serves as the sum; with a smaller
// population a summing pass over the entries in use comes first. A zero sum gives a uniform
// pick, random_word modulo the population, from a 16-step remainder unit. The store reads one
// entry a cycle through its single port, and that scan sets the select time. One transfer is
// worked on at a time; a finished result waits in the output register while the next
// transfer is taken. The store is empty after reset with no clearing pass.
module roulette_wheel_selector_top import rws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [POP_W-1:0] cfg_wr_data,
    rws_in_if.sink           items,
    rws_out_if.source        results
);

    cmd_t    cmd;
    status_t st;
    logic    in_ready;

    assign items.ready = in_ready;

    rws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_op    (items.operation),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    rws_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .entry_index    (items.entry_index),
        .fitness_weight (items.fitness_weight),
        .random_word    (items.random_word),
        .cmd            (cmd),
        .st             (st),
        .results        (results)
    );

    // a load never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready && (items.operation == OP_LOAD) && !results.valid
        |=> !results.valid)
        else $error("result appeared after a load");

    // after a transfer in, the block is busy and the input is not ready in the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("input taken again while busy");

    // a new result is only produced while an item is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> !$past(items.ready))
        else $error("result raised while idle");

endmodule
